/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the positional list engine.
// Request and status codes, port field widths, default sizes, result struct.
// No dependencies.
package ple_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int REQ_W  = 2;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

/* rtl/ple_seq.sv */
`timescale 1ns / 1ps
// Sequencer and element memory of the positional list engine.
// Walks the memory one entry per cycle to open or close a gap at a rank.
// Depends on ple_pkg.
module ple_seq #(
  parameter int CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ple_pkg::REQ_W-1:0]  req_type,
  input  logic [ple_pkg::POS_W-1:0]  position,
  input  logic [ple_pkg::WORD_W-1:0] data_in,
  output logic                       res_done,
  input  logic                       res_free,
  output ple_pkg::res_t              res
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int RW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_RD_WAIT   = 3'd1;
  localparam logic [2:0] S_INS_SHIFT = 3'd2;
  localparam logic [2:0] S_INS_PUT   = 3'd3;
  localparam logic [2:0] S_DEL_GET   = 3'd4;
  localparam logic [2:0] S_DEL_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;

  logic [2:0]            state;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         ptr;
  logic [AW-1:0]         rank;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] res_data;
  logic [ST_W-1:0]       res_status;

  logic [RW-1:0]         pos_ext;
  logic [RW-1:0]         cnt_ext;
  logic [AW-1:0]         pos_a;
  logic [CW-1:0]         cnt_m1;
  logic [DATA_WIDTH-1:0] din;
  logic                  ins_bad;
  logic                  rd_bad;
  logic                  is_full;
  logic                  ins_tail;
  logic                  ins_last;
  logic                  del_last;
  logic                  del_end;

  assign pos_ext  = RW'(position);
  assign cnt_ext  = RW'(cnt);
  assign pos_a    = pos_ext[AW-1:0];
  assign cnt_m1   = cnt - CW'(1);
  assign din      = DATA_WIDTH'(data_in);
  assign ins_bad  = pos_ext > cnt_ext;
  assign rd_bad   = pos_ext >= cnt_ext;
  assign is_full  = cnt == CW'(CAPACITY);
  assign ins_tail = pos_ext == cnt_ext;
  assign ins_last = (ptr - AW'(1)) == rank;
  assign del_last = ((CW+1)'(rank) + (CW+1)'(1)) >= (CW+1)'(cnt);
  assign del_end  = ((CW+1)'(ptr) + (CW+1)'(2)) >= (CW+1)'(cnt);

  assign in_stall   = state != S_IDLE;
  assign res_done   = state == S_DONE;
  assign res.data   = WORD_W'(res_data);
  assign res.status = res_status;
  assign res.count  = CNT_W'(cnt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = ptr;
    wdata  = rd_data;
    raddr  = ptr;
    unique case (state)
      S_IDLE: begin
        raddr = pos_a;
        if (in_valid && req_type == REQ_INSERT) begin
          if (!ins_bad && !is_full && ins_tail) begin
            mem_we = 1'b1;
            waddr  = pos_a;
            wdata  = din;
          end else begin
            raddr = cnt_m1[AW-1:0];
          end
        end
      end
      S_INS_SHIFT: begin
        mem_we = 1'b1;
        raddr  = ptr - AW'(2);
      end
      S_INS_PUT: begin
        mem_we = 1'b1;
        waddr  = rank;
        wdata  = word;
      end
      S_DEL_GET: begin
        raddr = rank + AW'(1);
      end
      S_DEL_SHIFT: begin
        mem_we = 1'b1;
        raddr  = ptr + AW'(2);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rank     <= pos_a;
            word     <= din;
            res_data <= '0;
            unique case (req_type)
              REQ_INSERT: begin
                if (ins_bad) begin
                  res_status <= ST_BADPOS;
                  state      <= S_DONE;
                end else if (is_full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (ins_tail) begin
                  res_status <= ST_OK;
                  cnt        <= cnt + CW'(1);
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  ptr        <= cnt[AW-1:0];
                  state      <= S_INS_SHIFT;
                end
              end
              REQ_DELETE: begin
                res_status <= rd_bad ? ST_BADPOS : ST_OK;
                state      <= rd_bad ? S_DONE : S_DEL_GET;
              end
              REQ_READ: begin
                res_status <= rd_bad ? ST_BADPOS : ST_OK;
                state      <= rd_bad ? S_DONE : S_RD_WAIT;
              end
              default: begin
                res_status <= ST_BADPOS;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          res_data <= rd_data;
          state    <= S_DONE;
        end
        S_INS_SHIFT: begin
          if (ins_last) begin
            state <= S_INS_PUT;
          end else begin
            ptr <= ptr - AW'(1);
          end
        end
        S_INS_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_DONE;
        end
        S_DEL_GET: begin
          res_data <= rd_data;
          ptr      <= rank;
          if (del_last) begin
            cnt   <= cnt - CW'(1);
            state <= S_DONE;
          end else begin
            state <= S_DEL_SHIFT;
          end
        end
        S_DEL_SHIFT: begin
          if (del_end) begin
            cnt   <= cnt - CW'(1);
            state <= S_DONE;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps
// Top level of the positional list engine: sequencer plus output register.
// Depends on ple_pkg and ple_seq.
//
//   channel   valid       stall       payload
//   request   in_valid    in_stall    req_type, position, data_in
//   result    out_valid   out_stall   data_out, status, count
//
// Read fetches the word. Insert at rank r shifts entries from the tail to r, then writes
// the word; a tail insert writes at once. Delete shifts later entries down.
// The walk moves one entry per cycle: one read and one write a cycle in the element memory.
// Reset clears the count, sequencer state and out_valid; memory contents are not cleared.
// A waiting result does not block the next request; a stalled output holds the
// sequencer at the end of the following request until the register drains.
module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ple_pkg::REQ_W-1:0]   req_type,
  input  logic [ple_pkg::POS_W-1:0]   position,
  input  logic [ple_pkg::WORD_W-1:0]  data_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ple_pkg::WORD_W-1:0]  data_out,
  output logic [ple_pkg::ST_W-1:0]    status,
  output logic [ple_pkg::CNT_W-1:0]   count
);
  import ple_pkg::*;

  logic res_done;
  logic res_free;
  res_t res;

  assign res_free = !out_valid || !out_stall;

  ple_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .position (position),
    .data_in  (data_in),
    .res_done (res_done),
    .res_free (res_free),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_done && res_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done && res_free) begin
      data_out <= res.data;
      status   <= res.status;
      count    <= res.count;
    end
  end

endmodule

/* rtl/ple_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg.
module ple_checker #(
  parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ple_pkg::WORD_W-1:0] data_out,
  input logic [ple_pkg::ST_W-1:0]   status,
  input logic [ple_pkg::CNT_W-1:0]  count
);
  import ple_pkg::*;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while a request is in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data_out == '0)
    else $error("nonzero word on a refused request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == CAP_C)
    else $error("full status below capacity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(count))
    else $error("stalled result beat changed");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data_out  (data_out),
  .status    (status),
  .count     (count)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for positional_list_engine: directed and random rank requests,
// with every result beat compared against a behavioral copy of the list.
// Depends on ple_pkg and the engine RTL.
module testbench;
  import ple_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int N_RANDOM = 1900;
  localparam int PHASE_LEN = 150;
  localparam int SETTLE_CYCLES = CAP + 16;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    int                gap;
    bit                drain;
  } list_req_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  req_type  = '0;
  logic [POS_W-1:0]  position  = '0;
  logic [WORD_W-1:0] data_in   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] data_out;
  logic [ST_W-1:0]   status;
  logic [CNT_W-1:0]  count;

  list_req_t req_q[$];
  res_t      want_q[$];
  list_req_t cur_req;
  res_t      want;
  int        idle_left  = 0;
  int        stall_left = 0;
  int        n_issued   = 0;
  int        n_done     = 0;
  int        n_errors   = 0;
  int        gen_len    = 0;

  logic [WORD_W-1:0] list_words [CAP];
  int                list_len = 0;

  positional_list_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .position  (position),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .status    (status),
    .count     (count)
  );

  always #5 clk = ~clk;

  function automatic res_t list_apply(list_req_t r);
    res_t res;
    int   rank;
    int   i;
    rank       = int'(r.pos);
    res.data   = '0;
    res.status = ST_BADPOS;
    case (r.kind)
      REQ_INSERT: begin
        if (rank > list_len) begin
          res.status = ST_BADPOS;
        end else if (list_len >= CAP) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > rank; i--)
            list_words[i] = list_words[i-1];
          list_words[rank] = r.word;
          list_len++;
          res.status = ST_OK;
        end
      end
      REQ_DELETE: begin
        if (rank < list_len) begin
          res.data = list_words[rank];
          for (i = rank; i + 1 < list_len; i++)
            list_words[i] = list_words[i+1];
          list_len--;
          res.status = ST_OK;
        end
      end
      REQ_READ: begin
        if (rank < list_len) begin
          res.data   = list_words[rank];
          res.status = ST_OK;
        end
      end
      default: res.status = ST_BADPOS;
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  task automatic add_req(input logic [REQ_W-1:0] kind, input int pos,
                         input logic [WORD_W-1:0] word, input int gap, input bit drain);
    list_req_t r;
    r.kind  = kind;
    r.pos   = POS_W'(pos);
    r.word  = word;
    r.gap   = gap;
    r.drain = drain;
    req_q.push_back(r);
    if (kind == REQ_INSERT && pos <= gen_len && gen_len < CAP)
      gen_len++;
    else if (kind == REQ_DELETE && pos < gen_len)
      gen_len--;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want_q.push_back(list_apply(cur_req));
        n_issued++;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0 && (!req_q[0].drain || n_issued == n_done)) begin
          cur_req = req_q.pop_front();
          idle_left = cur_req.gap;
          req_type <= cur_req.kind;
          position <= cur_req.pos;
          data_in  <= cur_req.word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t: result beat with nothing pending: data_out %h status %0d count %0d",
                   $time, data_out, status, count);
          n_errors++;
        end else begin
          want = want_q.pop_front();
          if (data_out !== want.data) begin
            $display("%0t: data_out expected %h got %h", $time, want.data, data_out);
            n_errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
            n_errors++;
          end
          if (count !== want.count) begin
            $display("%0t: count expected %0d got %0d", $time, want.count, count);
            n_errors++;
          end
          n_done <= n_done + 1;
        end
        stall_left = ((n_done / PHASE_LEN) % 3 == 2) ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int                k;
    int                phase;
    int                ins_pct;
    int                del_pct;
    int                roll;
    int                lim;
    int                pos;
    int                pick;
    logic [REQ_W-1:0]  kind;
    logic [WORD_W-1:0] word;

    add_req(REQ_READ,   0,   32'h1234_5678, $urandom_range(0, 9), 1'b0);
    add_req(REQ_DELETE, 0,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_INSERT, 1,   32'hDEAD_BEEF, $urandom_range(0, 9), 1'b0);
    add_req(REQ_UNUSED, 0,   32'hFFFF_FFFF, $urandom_range(0, 9), 1'b0);
    add_req(REQ_INSERT, 0,   32'hFFFF_FFFF, $urandom_range(0, 9), 1'b0);
    add_req(REQ_INSERT, 1,   32'h0000_0000, $urandom_range(0, 9), 1'b0);
    add_req(REQ_INSERT, 0,   32'hA5A5_A5A5, $urandom_range(0, 9), 1'b0);
    add_req(REQ_INSERT, 1,   32'h5A5A_5A5A, $urandom_range(0, 9), 1'b0);
    add_req(REQ_READ,   3,   32'hFFFF_FFFF, $urandom_range(0, 9), 1'b0);
    add_req(REQ_READ,   4,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_READ,   127, 32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_INSERT, 127, 32'h1111_1111, $urandom_range(0, 9), 1'b0);
    add_req(REQ_INSERT, 5,   32'h2222_2222, $urandom_range(0, 9), 1'b0);
    add_req(REQ_DELETE, 4,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_DELETE, 1,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_DELETE, 2,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_READ,   1,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_DELETE, 0,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_UNUSED, 127, 32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_READ,   0,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_DELETE, 0,   32'h0,         $urandom_range(0, 9), 1'b0);
    add_req(REQ_READ,   0,   32'h0,         $urandom_range(0, 9), 1'b0);

    // grow, mix, shrink, mix without sender gaps
    for (k = 0; k < N_RANDOM; k++) begin
      phase   = (k / PHASE_LEN) % 4;
      ins_pct = (phase == 0) ? 80 : (phase == 2) ? 15 : 40;
      del_pct = (phase == 0) ? 10 : (phase == 2) ? 65 : 35;
      roll    = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3)
        kind = REQ_UNUSED;
      else if (roll < ins_pct)
        kind = REQ_INSERT;
      else if (roll < ins_pct + del_pct)
        kind = REQ_DELETE;
      else
        kind = REQ_READ;

      lim  = (kind == REQ_INSERT) ? gen_len : gen_len - 1;
      pick = $urandom_range(0, 99);
      if (pick < 8)
        pos = $urandom_range(0, 127);
      else if (pick < 14 || lim < 0)
        pos = lim + 1;
      else if (pick < 24)
        pos = lim;
      else if (pick < 30)
        pos = 0;
      else
        pos = $urandom_range(0, lim);

      case ($urandom_range(0, 15))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase

      add_req(kind, pos, word, (phase == 3) ? 0 : $urandom_range(0, 9), (k % 500) == 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || in_valid || n_issued != n_done)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
